// ===== design/pat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg: shared definitions for the packet airtime calculator
// Status codes, field widths and the reciprocal table that the payload
// ceiling division uses.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int BwW      = 2;
    localparam int SfW      = 4;
    localparam int CrW      = 3;
    localparam int PreW     = 16;
    localparam int LenW     = 8;
    localparam int ToaW     = 32;
    localparam int QsymW    = 19;
    localparam int PaySymW  = 10;
    localparam int TsymW    = 16;
    localparam int StatW    = 2;

    // Reciprocal scaling: quotient = (x * recip) >> RcpShift.
    localparam int RcpShift = 16;
    localparam int RcpW     = 15;
    localparam int DivInW   = 10;

    typedef logic [StatW-1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BAD_SF = 2'd1;
    localparam t_status ST_BAD_BW = 2'd2;
    localparam t_status ST_BAD_CR = 2'd3;

    // ceil(2^16 / k) for the divisors that valid spreading factors produce.
    // The error stays small enough that the floor is exact for 10-bit inputs.
    function automatic logic [RcpW-1:0] f_recip(input logic [SfW-1:0] k);
        logic [RcpW-1:0] r;
        case (k)
            4'd5:    r = 15'd13108;
            4'd6:    r = 15'd10923;
            4'd7:    r = 15'd9363;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd7282;
            4'd10:   r = 15'd6554;
            default: r = 15'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/packet_airtime_calculator.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; a new
// word may enter every cycle unless o_in_stall is high. The rate is set
// by the four-stage pipeline (decode, reciprocal multiply, payload
// scaling, airtime multiply), each stage holding one word.
// Reset (synchronous, active low) clears all stage valid bits; no word is
// presented after reset until one has passed through the pipeline.
// ----------------------------------------------------------------------------
// packet_airtime_calculator
// Computes the time on air of a LoRa packet from its modulation settings and
// payload length, along with symbol counts and the symbol duration.
// ----------------------------------------------------------------------------
module packet_airtime_calculator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [pat_pkg::BwW-1:0]     i_bandwidth_sel,
    input  logic [pat_pkg::SfW-1:0]     i_spread_factor,
    input  logic [pat_pkg::CrW-1:0]     i_coding_rate,
    input  logic [pat_pkg::PreW-1:0]    i_preamble_symbols,
    input  logic                       i_implicit_header,
    input  logic                       i_crc_absent,
    input  logic [pat_pkg::LenW-1:0]    i_payload_bytes,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [pat_pkg::ToaW-1:0]    o_airtime_us,
    output logic [pat_pkg::QsymW-1:0]   o_total_quarter_symbols,
    output logic [pat_pkg::PaySymW-1:0] o_payload_symbol_count,
    output logic [pat_pkg::TsymW-1:0]   o_symbol_time_us,
    output logic [pat_pkg::StatW-1:0]   o_status
);
    import pat_pkg::*;

    // The whole pipeline moves together. It advances whenever the output
    // register is empty or its word is being taken, so a stall freezes every
    // stage in place and nothing is lost or repeated.
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: validate the settings and reduce the payload term.
    // The payload divisor is 4*k with k = sf, or sf-2 when low data rate
    // optimization applies (sf of 11 and above). ceil(n / 4k) is taken as
    // ceil(ceil(n / 4) / k), and the division by k becomes a multiply by a
    // scaled reciprocal.
    // ------------------------------------------------------------------
    t_status             n_st1;
    logic                sf_ok;
    logic                sf_hi;
    logic                de;
    logic [SfW-1:0]      k;
    logic [11:0]         pos_term;
    logic [11:0]         neg_term;
    logic [11:0]         num;
    logic [9:0]          num_q;
    logic [DivInW-1:0]   n_x1;
    logic [19:0]         tsym_wide;
    logic [QsymW-1:0]    n_base1;

    always_comb begin
        sf_ok = (i_spread_factor >= 4'd5) && (i_spread_factor <= 4'd12);
        if (!sf_ok) begin
            n_st1 = ST_BAD_SF;
        end else if (i_bandwidth_sel > 2'd2) begin
            n_st1 = ST_BAD_BW;
        end else if ((i_coding_rate < 3'd1) || (i_coding_rate > 3'd4)) begin
            n_st1 = ST_BAD_CR;
        end else begin
            n_st1 = ST_OK;
        end

        sf_hi = (i_spread_factor >= 4'd7);
        de    = (i_spread_factor >= 4'd11);
        k     = de ? (i_spread_factor - 4'd2) : i_spread_factor;

        pos_term = {1'b0, i_payload_bytes, 3'b000}
                 + (i_crc_absent      ? 12'd0 : 12'd16)
                 + (sf_hi             ? 12'd8 : 12'd0)
                 + (i_implicit_header ? 12'd0 : 12'd20);
        neg_term = {6'd0, i_spread_factor, 2'b00};
        // A negative payload term counts as zero payload symbols.
        num   = (pos_term > neg_term) ? (pos_term - neg_term) : 12'd0;
        num_q = 10'((num + 12'd3) >> 2);
        n_x1  = num_q + DivInW'(k) - DivInW'(1);

        tsym_wide = (20'd8 << i_spread_factor) >> i_bandwidth_sel;

        // Preamble plus 4.25 (or 6.25 below sf 7) plus the fixed 8 symbols.
        n_base1 = {1'b0, i_preamble_symbols, 2'b00}
                + (sf_hi ? QsymW'(49) : QsymW'(57));
    end

    logic                r_v1;
    t_status             r_st1;
    logic [DivInW-1:0]   r_x1;
    logic [RcpW-1:0]     r_rcp1;
    logic [3:0]          r_cr1;
    logic [TsymW-1:0]    r_ts1;
    logic [QsymW-1:0]    r_base1;

    // ------------------------------------------------------------------
    // Stage 2: reciprocal multiply.
    // ------------------------------------------------------------------
    logic                r_v2;
    t_status             r_st2;
    logic [DivInW+RcpW-1:0] r_prod2;
    logic [3:0]          r_cr2;
    logic [TsymW-1:0]    r_ts2;
    logic [QsymW-1:0]    r_base2;

    // ------------------------------------------------------------------
    // Stage 3: scale by the coding rate and form the quarter symbol count.
    // ------------------------------------------------------------------
    logic [DivInW+RcpW-RcpShift-1:0] quot;
    logic [12:0]         pay_wide;
    logic [PaySymW-1:0]  n_pay3;
    logic [QsymW-1:0]    n_qs3;

    assign quot     = r_prod2[DivInW+RcpW-1:RcpShift];
    assign pay_wide = quot * r_cr2;
    assign n_pay3   = pay_wide[PaySymW-1:0];
    assign n_qs3    = r_base2 + QsymW'({n_pay3, 2'b00});

    logic                r_v3;
    t_status             r_st3;
    logic [PaySymW-1:0]  r_pay3;
    logic [QsymW-1:0]    r_qs3;
    logic [TsymW-1:0]    r_ts3;

    // ------------------------------------------------------------------
    // Stage 4: airtime = quarters * symbol time / 4. The symbol time is a
    // multiple of 4 us, so dropping the two low bits loses nothing.
    // ------------------------------------------------------------------
    logic [QsymW+TsymW-1:0] toa_prod;
    assign toa_prod = r_qs3 * r_ts3;

    logic                r_v4;
    t_status             r_st4;
    logic [ToaW-1:0]     r_toa4;
    logic [QsymW-1:0]    r_qs4;
    logic [PaySymW-1:0]  r_pay4;
    logic [TsymW-1:0]    r_ts4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st1   <= n_st1;
            r_x1    <= n_x1;
            r_rcp1  <= f_recip(k);
            r_cr1   <= {1'b0, i_coding_rate} + 4'd4;
            r_ts1   <= tsym_wide[TsymW-1:0];
            r_base1 <= n_base1;

            r_st2   <= r_st1;
            r_prod2 <= r_x1 * r_rcp1;
            r_cr2   <= r_cr1;
            r_ts2   <= r_ts1;
            r_base2 <= r_base1;

            r_st3   <= r_st2;
            r_pay3  <= n_pay3;
            r_qs3   <= n_qs3;
            r_ts3   <= r_ts2;

            r_st4   <= r_st3;
            r_toa4  <= toa_prod[ToaW+1:2];
            r_qs4   <= r_qs3;
            r_pay4  <= r_pay3;
            r_ts4   <= r_ts3;
        end
    end

    // Any failed check forces all numeric results to zero.
    logic ok4;
    assign ok4 = (r_st4 == ST_OK);

    assign o_out_valid             = r_v4;
    assign o_status                = r_st4;
    assign o_airtime_us            = ok4 ? r_toa4 : '0;
    assign o_total_quarter_symbols = ok4 ? r_qs4  : '0;
    assign o_payload_symbol_count  = ok4 ? r_pay4 : '0;
    assign o_symbol_time_us        = ok4 ? r_ts4  : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_v3)))
        else $error("pipeline moved during a stall");

    a_valid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v3) |=> r_v4)
        else $error("valid word dropped between stages");

    a_pay_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (r_st3 == ST_OK)) |-> (r_pay3 <= PaySymW'(832)))
        else $error("payload symbol count out of range");

    a_tsym_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && ok4) |-> ((r_ts4 != '0) && (r_qs4 >= QsymW'(49))))
        else $error("valid settings gave an empty symbol time or count");

endmodule

// ===== bench/packet_airtime_calculator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_airtime_calculator_tb: self-checking bench for the airtime calculator
// Drives packet descriptions through the input channel with random gaps and
// random output stalls. Each accepted word is turned into its expected time
// on air, symbol counts, symbol time and status, and every result word is
// compared field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module packet_airtime_calculator_tb;

    import pat_pkg::*;

    typedef struct packed {
        logic [BwW-1:0]  bw;
        logic [SfW-1:0]  sf;
        logic [CrW-1:0]  cr;
        logic [PreW-1:0] pre;
        logic            hdr_off;
        logic            crc_off;
        logic [LenW-1:0] len;
    } t_packet;

    typedef struct packed {
        logic [ToaW-1:0]    toa;
        logic [QsymW-1:0]   qsym;
        logic [PaySymW-1:0] pay;
        logic [TsymW-1:0]   tsym;
        t_status            status;
    } t_airtime;

    localparam int RandomPackets = 1130;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [BwW-1:0]  bandwidth_sel = '0;
    logic [SfW-1:0]  spread_factor = '0;
    logic [CrW-1:0]  coding_rate = '0;
    logic [PreW-1:0] preamble_symbols = '0;
    logic            implicit_header = 1'b0;
    logic            crc_absent = 1'b0;
    logic [LenW-1:0] payload_bytes = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [ToaW-1:0]    airtime_us;
    logic [QsymW-1:0]   total_quarter_symbols;
    logic [PaySymW-1:0] payload_symbol_count;
    logic [TsymW-1:0]   symbol_time_us;
    logic [StatW-1:0]   status;

    t_packet  packets_pending[$];
    t_airtime airtime_expected[$];

    int send_gap = 0;
    int stall_left = 0;
    int words_sent = 0;
    int words_checked = 0;
    int words_rejected = 0;
    int mismatches = 0;

    packet_airtime_calculator dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_bandwidth_sel        (bandwidth_sel),
        .i_spread_factor        (spread_factor),
        .i_coding_rate          (coding_rate),
        .i_preamble_symbols     (preamble_symbols),
        .i_implicit_header      (implicit_header),
        .i_crc_absent           (crc_absent),
        .i_payload_bytes        (payload_bytes),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_airtime_us           (airtime_us),
        .o_total_quarter_symbols(total_quarter_symbols),
        .o_payload_symbol_count (payload_symbol_count),
        .o_symbol_time_us       (symbol_time_us),
        .o_status               (status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Expected result for one packet description. Checks run in priority
    // order: spreading factor, then bandwidth, then coding rate.
    function automatic t_airtime airtime_of(t_packet p);
        t_airtime r;
        int sf;
        int sym_us;
        int numer;
        int divisor;
        int pay_syms;
        int quarters;
        logic [63:0] toa_full;
        r = '0;
        sf = int'(p.sf);
        if (sf < 5 || sf > 12) begin
            r.status = ST_BAD_SF;
            return r;
        end
        if (p.bw > 2) begin
            r.status = ST_BAD_BW;
            return r;
        end
        if (p.cr < 1 || p.cr > 4) begin
            r.status = ST_BAD_CR;
            return r;
        end
        sym_us = (8 << sf) >> int'(p.bw);
        // Payload bits beyond what the first symbols carry; clamped at zero
        // before the ceiling division.
        numer = 8 * int'(p.len) + (p.crc_off ? 0 : 16) - 4 * sf
              + ((sf >= 7) ? 8 : 0) + (p.hdr_off ? 0 : 20);
        if (numer < 0) begin
            numer = 0;
        end
        // Low data rate optimization takes two bits per symbol from sf 11 on.
        divisor = 4 * (sf - ((sf >= 11) ? 2 : 0));
        pay_syms = ((numer + divisor - 1) / divisor) * (int'(p.cr) + 4);
        // Preamble plus 4.25 (or 6.25 below sf 7), 8 fixed, then payload.
        quarters = 4 * int'(p.pre) + ((sf >= 7) ? 17 : 25) + 32 + 4 * pay_syms;
        toa_full = (64'(quarters) * 64'(sym_us)) >> 2;
        r.toa = toa_full[ToaW-1:0];
        r.qsym = quarters[QsymW-1:0];
        r.pay = pay_syms[PaySymW-1:0];
        r.tsym = sym_us[TsymW-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int idle_draw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic add_packet(input int bw, input int sf, input int cr, input int pre,
                              input int hdr_off, input int crc_off, input int len);
        t_packet p;
        p.bw = BwW'(bw);
        p.sf = SfW'(sf);
        p.cr = CrW'(cr);
        p.pre = PreW'(pre);
        p.hdr_off = hdr_off[0];
        p.crc_off = crc_off[0];
        p.len = LenW'(len);
        packets_pending.push_back(p);
    endtask

    // Mostly legal settings with random content; a share of the words are
    // fully random so the rejection paths keep getting exercised.
    function automatic t_packet random_packet();
        t_packet p;
        int pick;
        p = t_packet'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            p.bw = BwW'($urandom_range(0, 2));
            p.sf = SfW'($urandom_range(5, 12));
            p.cr = CrW'($urandom_range(1, 4));
            if ($urandom_range(0, 9) < 8) begin
                p.pre = PreW'($urandom_range(0, 16));
            end
            if (pick >= 72) begin
                // Short payloads sit near the point where the term clamps.
                p.len = LenW'($urandom_range(0, 8));
            end
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: word %0d %s mismatch, expected %0d, got %0d",
                         $realtime, words_checked, name, want, got);
            end
        end
    endtask

    // Input side: a new word is loaded only when nothing is presented or the
    // presented word is taken at this edge, so a stalled word holds still.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                airtime_expected.push_back(airtime_of({bandwidth_sel, spread_factor,
                    coding_rate, preamble_symbols, implicit_header, crc_absent,
                    payload_bytes}));
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (packets_pending.size() > 0) begin
                    {bandwidth_sel, spread_factor, coding_rate, preamble_symbols,
                     implicit_header, crc_absent, payload_bytes}
                        <= packets_pending.pop_front();
                    in_valid <= 1'b1;
                    words_sent++;
                    // Every third stretch of 200 words runs back to back.
                    send_gap <= ((words_sent / 200) % 3 == 2) ? 0 : idle_draw();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stall bursts, with quiet stretches mixed in.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            int n;
            n = ((words_checked / 170) % 4 == 1) ? 0 : idle_draw();
            out_stall <= (n > 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    // Result checker.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            t_airtime want;
            if (airtime_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result word with no packet outstanding", $realtime);
                end
            end else begin
                want = airtime_expected.pop_front();
                check_field("airtime_us", 64'(want.toa), 64'(airtime_us));
                check_field("total_quarter_symbols", 64'(want.qsym),
                            64'(total_quarter_symbols));
                check_field("payload_symbol_count", 64'(want.pay),
                            64'(payload_symbol_count));
                check_field("symbol_time_us", 64'(want.tsym), 64'(symbol_time_us));
                check_field("status", 64'(want.status), 64'(status));
                if (want.status != ST_OK) begin
                    words_rejected++;
                end
                words_checked++;
            end
        end
    end

    initial begin
        // Directed words: longest packet, rejection priorities, every coding
        // rate, both bandwidth extremes, clamped payload terms and the short
        // spreading factors with the longer preamble.
        add_packet(0, 12, 4, 65535, 0, 0, 255);
        add_packet(0, 0, 0, 0, 0, 0, 0);
        add_packet(3, 4, 0, 100, 1, 1, 10);
        add_packet(0, 13, 1, 8, 0, 0, 20);
        add_packet(3, 15, 7, 65535, 1, 1, 255);
        add_packet(3, 7, 1, 8, 0, 0, 20);
        add_packet(3, 7, 0, 8, 0, 0, 20);
        add_packet(0, 7, 0, 8, 0, 0, 20);
        add_packet(1, 9, 5, 8, 0, 0, 20);
        add_packet(2, 11, 7, 8, 0, 0, 20);
        add_packet(2, 5, 1, 0, 1, 1, 0);
        add_packet(1, 6, 2, 8, 0, 0, 10);
        add_packet(0, 7, 3, 12, 1, 1, 0);
        add_packet(1, 10, 4, 8, 0, 0, 255);
        add_packet(2, 11, 1, 8, 0, 1, 51);
        add_packet(0, 12, 1, 0, 1, 1, 0);
        add_packet(2, 8, 2, 65535, 0, 1, 128);
        add_packet(1, 9, 3, 1, 1, 0, 1);
        add_packet(0, 5, 4, 65535, 0, 0, 255);
        add_packet(2, 12, 4, 0, 1, 0, 255);
        add_packet(0, 6, 1, 6, 0, 1, 3);
        for (int i = 0; i < RandomPackets; i++) begin
            packets_pending.push_back(random_packet());
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (packets_pending.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (airtime_expected.size() != 0) begin
            @(posedge clk);
        end
        // Four-stage pipeline; leave room for any stray extra word.
        repeat (20) @(posedge clk);

        $display("Sent %0d packet descriptions; %0d results checked, %0d of them rejected.",
                 words_sent, words_checked, words_rejected);
        $display("Field mismatches or unexpected words: %0d", mismatches);
        if (mismatches == 0 && airtime_expected.size() == 0) begin
            $display("packet_airtime_calculator test passed");
        end else begin
            $display("packet_airtime_calculator test failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run of this stimulus.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding", airtime_expected.size());
        $display("packet_airtime_calculator test failed");
        $finish;
    end

endmodule
